/* rtl/core/pfb_pkg.sv */
package pfb_pkg;

    // Source pixel formats selected by the source_format register
    typedef enum logic [1:0] {
        FMT_BGRA8   = 2'd0,
        FMT_RGBA8   = 2'd1,
        FMT_RGB10A2 = 2'd2,
        FMT_RGBA16F = 2'd3
    } t_src_fmt;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_FORMAT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_WHITE_SCALE = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam t_src_fmt    SOURCE_FORMAT_RST   = FMT_BGRA8;
    localparam logic [15:0] INV_WHITE_SCALE_RST = 16'h8000;

    localparam int unsigned SRGB_TABLE_INDEX_BITS_DEF = 12;
    localparam int unsigned TBL_DATA_W = 16;

    // Fixed point constants of the half float path (linear value in Q0.24)
    localparam logic [24:0] Q24_ONE    = 25'h100_0000;
    localparam logic [24:0] LIN_LIMIT  = 25'd52525;
    localparam logic [15:0] LIN_SLOPE  = 16'd32946;
    localparam logic [30:0] LIN_BIAS   = 31'h500_0000;
    localparam logic [7:0]  BYTE_FULL  = 8'hFF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // Power curve table scaling
    localparam logic [63:0] SRGB_OFFSET = 64'd55 << 30;
    localparam logic [63:0] SRGB_DEN    = 64'd1000 << 30;
    localparam logic [63:0] SRGB_Q88    = 64'd65280;

    // Per channel classification along the half float pipeline
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_FULL,
        CLS_CALC,
        CLS_LINEAR,
        CLS_CURVE
    } t_pfb_class;

    typedef struct packed {
        t_src_fmt    source_format;
        logic [15:0] inv_white_scale;
    } t_pfb_cfg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_pfb_bgra;

    // Floor integer cube root, 21 result bits
    function automatic logic [63:0] int_cbrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 20; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c * c <= x) r = c;
        end
        return r;
    endfunction

    // Floor integer square root, 31 result bits
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 30; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    // One Q8.8 entry of the sRGB power curve; x^(1/2.4) = cbrt(x) * cbrt(x)^(1/4)
    function automatic logic [TBL_DATA_W-1:0] srgb_entry(input int i, input int bits);
        logic [63:0] x60;
        logic [63:0] c20;
        logic [63:0] s30;
        logic [63:0] q30;
        logic [63:0] y30;
        logic [63:0] a;
        x60 = 64'(i) << (60 - bits);
        c20 = int_cbrt(x60);
        s30 = int_sqrt(c20 << 40);
        q30 = int_sqrt(s30 << 30);
        y30 = (c20 * q30) >> 20;
        a   = 64'd1055 * y30;
        if (a <= SRGB_OFFSET) return '0;
        return TBL_DATA_W'(((a - SRGB_OFFSET) * SRGB_Q88 + SRGB_DEN / 2) / SRGB_DEN);
    endfunction

endpackage

/* rtl/core/pfb_ram.sv */
module pfb_ram
    import pfb_pkg::*;
#(
    parameter int unsigned WIDTH = TBL_DATA_W,
    parameter int unsigned DEPTH = (1 << SRGB_TABLE_INDEX_BITS_DEF) + 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* rtl/core/pfb_table_fill.sv */
module pfb_table_fill
    import pfb_pkg::*;
#(
    parameter int unsigned IDX_BITS = SRGB_TABLE_INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    output logic                  o_we,
    output logic [IDX_BITS:0]     o_waddr,
    output logic [TBL_DATA_W-1:0] o_wdata,
    output logic                  o_done
);

    localparam int unsigned TBL_DEPTH = (1 << IDX_BITS) + 1;
    localparam int unsigned ADDR_W    = IDX_BITS + 1;

    logic [TBL_DATA_W-1:0] w_rom [TBL_DEPTH];

    // Curve entries are worked out at elaboration
    for (genvar gi = 0; gi < TBL_DEPTH; gi++) begin : g_rom
        localparam logic [TBL_DATA_W-1:0] ENTRY = srgb_entry(gi, IDX_BITS);
        assign w_rom[gi] = ENTRY;
    end

    logic                  r_run;
    logic [ADDR_W-1:0]     r_cnt;
    logic                  r_we;
    logic [ADDR_W-1:0]     r_waddr;
    logic [TBL_DATA_W-1:0] r_wdata;

    // Sweep counter, one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_cnt <= '0;
            r_we  <= 1'b0;
        end else begin
            r_we <= r_run;
            if (r_run) begin
                r_cnt <= r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(TBL_DEPTH - 1)) r_run <= 1'b0;
            end
        end
    end

    // Registered table read feeding the write port
    always_ff @(posedge i_clk) begin
        r_waddr <= r_cnt;
        r_wdata <= w_rom[r_cnt];
    end

    assign o_we    = r_we;
    assign o_waddr = r_waddr;
    assign o_wdata = r_wdata;
    assign o_done  = !r_run && !r_we;

endmodule

/* rtl/core/pfb_lane.sv */
module pfb_lane
    import pfb_pkg::*;
#(
    parameter int unsigned IDX_BITS = SRGB_TABLE_INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_pfb_cfg              i_cfg,
    input  logic [15:0]           i_half,
    input  logic [9:0]            i_unorm,
    input  logic [7:0]            i_byte,
    input  logic                  i_tbl_we,
    input  logic [IDX_BITS:0]     i_tbl_waddr,
    input  logic [TBL_DATA_W-1:0] i_tbl_wdata,
    output logic                  o_valid,
    output logic [7:0]            o_byte
);

    localparam int unsigned FRAC_W    = 24 - IDX_BITS;
    localparam int unsigned ADDR_W    = IDX_BITS + 1;
    localparam int unsigned TBL_DEPTH = (1 << IDX_BITS) + 1;
    localparam int unsigned IP_W      = TBL_DATA_W + FRAC_W;

    // ---------------- stage 1: decode, scale multiply, unorm10 rounding
    logic [4:0]       w_exp;
    logic [10:0]      w_mant;
    logic [4:0]       w_shl;
    t_pfb_class       w_cls1;
    logic [26:0]      w_prod;
    logic [17:0]      w_x;
    logic [10:0]      w_rem;
    logic [7:0]       w_unorm_byte;
    logic [7:0]       w_fix;

    assign w_exp  = i_half[14:10];
    assign w_mant = (w_exp == 5'd0) ? {1'b0, i_half[9:0]} : {1'b1, i_half[9:0]};
    // denormals use exponent 1; linear value is prod * 2^(exp-16)
    assign w_shl  = (w_exp == 5'd0) ? 5'd0 : w_exp - 5'd1;
    assign w_prod = w_mant * i_cfg.inv_white_scale;

    always_comb begin
        if (w_exp == 5'h1F) begin
            // NaN and -inf give 0, +inf saturates
            w_cls1 = ((i_half[9:0] != 10'd0) || i_half[15]) ? CLS_ZERO : CLS_FULL;
        end else if (i_half[15]) begin
            w_cls1 = CLS_ZERO;
        end else begin
            w_cls1 = CLS_CALC;
        end
    end

    // (v*255+511)/1023: quotient by 1024 then one correction step
    assign w_x          = 18'(i_unorm) * 18'd255 + 18'd511;
    assign w_rem        = 11'(w_x[9:0]) + 11'(w_x[17:10]);
    assign w_unorm_byte = w_x[17:10] + 8'(w_rem >= 11'd1023);
    assign w_fix        = (i_cfg.source_format == FMT_RGB10A2) ? w_unorm_byte : i_byte;

    logic        r1_vld;
    t_pfb_class  r1_cls;
    logic [26:0] r1_prod;
    logic [4:0]  r1_shl;
    logic [7:0]  r1_fix;

    // ---------------- stage 2: exponent shift and saturate to 1.0
    logic [55:0] w_wide;
    logic [40:0] w_w;
    logic [24:0] w_v;

    assign w_wide = 56'(r1_prod) << r1_shl;
    assign w_w    = w_wide[55:15];
    assign w_v    = (w_w > {16'd0, Q24_ONE}) ? Q24_ONE : w_w[24:0];

    logic        r2_vld;
    t_pfb_class  r2_cls;
    logic [24:0] r2_v;
    logic [7:0]  r2_fix;

    // ---------------- stage 3: classify, table read, linear segment product
    t_pfb_class         w_cls3;
    logic [ADDR_W-1:0]  w_addr_lo;
    logic [ADDR_W-1:0]  w_addr_hi;
    logic [30:0]        w_lin;

    always_comb begin
        w_cls3 = r2_cls;
        if (r2_cls == CLS_CALC) begin
            if (r2_v[24]) begin
                w_cls3 = CLS_FULL;
            end else if (r2_v <= LIN_LIMIT) begin
                w_cls3 = CLS_LINEAR;
            end else begin
                w_cls3 = CLS_CURVE;
            end
        end
    end

    assign w_addr_lo = {1'b0, r2_v[23:FRAC_W]};
    assign w_addr_hi = w_addr_lo + ADDR_W'(1);
    // L*32946 + 5*2^24, later divided by 10*2^24 as >>25 then /5
    assign w_lin     = 31'(r2_v[15:0]) * 31'(LIN_SLOPE) + LIN_BIAS;

    logic [TBL_DATA_W-1:0] w_tbl_lo;
    logic [TBL_DATA_W-1:0] w_tbl_hi;

    pfb_ram #(
        .WIDTH (TBL_DATA_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_we      (i_tbl_we),
        .i_waddr   (i_tbl_waddr),
        .i_wdata   (i_tbl_wdata),
        .i_re      (i_en),
        .i_raddr_a (w_addr_lo),
        .i_raddr_b (w_addr_hi),
        .o_rdata_a (w_tbl_lo),
        .o_rdata_b (w_tbl_hi)
    );

    logic              r3_vld;
    t_pfb_class        r3_cls;
    logic [5:0]        r3_t;
    logic [FRAC_W-1:0] r3_frac;
    logic [7:0]        r3_fix;

    // ---------------- stage 4: interpolate, finish linear divide
    logic [TBL_DATA_W-1:0] w_diff;
    logic [IP_W-1:0]       w_ip;
    logic [16:0]           w_acc;
    logic [9:0]            w_t13;

    assign w_diff = w_tbl_hi - w_tbl_lo;
    assign w_ip   = w_diff * r3_frac;
    assign w_acc  = {1'b0, w_tbl_lo} + 17'(w_ip >> FRAC_W);
    // t <= 54 here, so t*13/64 floors to t/5
    assign w_t13  = 10'(r3_t) * 10'd13;

    logic        r4_vld;
    t_pfb_class  r4_cls;
    logic [16:0] r4_acc;
    logic [3:0]  r4_lin;
    logic [7:0]  r4_fix;

    // ---------------- stage 5: round Q8.8 and pick the channel byte
    logic [17:0] w_rnd;
    logic [7:0]  w_curve;
    logic [7:0]  w_fp;
    logic [7:0]  w_byte5;

    assign w_rnd   = {1'b0, r4_acc} + 18'd128;
    assign w_curve = (|w_rnd[17:16]) ? BYTE_FULL : w_rnd[15:8];

    always_comb begin
        case (r4_cls)
            CLS_FULL:   w_fp = BYTE_FULL;
            CLS_LINEAR: w_fp = {4'd0, r4_lin};
            CLS_CURVE:  w_fp = w_curve;
            default:    w_fp = 8'd0;
        endcase
    end

    assign w_byte5 = (i_cfg.source_format == FMT_RGBA16F) ? w_fp : r4_fix;

    logic       r5_vld;
    logic [7:0] r5_byte;

    // Valid bits of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cls  <= w_cls1;
            r1_prod <= w_prod;
            r1_shl  <= w_shl;
            r1_fix  <= w_fix;

            r2_cls  <= r1_cls;
            r2_v    <= w_v;
            r2_fix  <= r1_fix;

            r3_cls  <= w_cls3;
            r3_t    <= w_lin[30:25];
            r3_frac <= r2_v[FRAC_W-1:0];
            r3_fix  <= r2_fix;

            r4_cls  <= r3_cls;
            r4_acc  <= w_acc;
            r4_lin  <= w_t13[9:6];
            r4_fix  <= r3_fix;

            r5_byte <= w_byte5;
        end
    end

    assign o_valid = r5_vld;
    assign o_byte  = r5_byte;

    // A live request past classification never stays unresolved
    a_cls_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld |-> (r3_cls != CLS_CALC))
        else $error("half float class left unresolved at stage 3");

endmodule

/* rtl/core/pfb_merge.sv */
module pfb_merge
    import pfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_lane_vld,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    input  logic       i_out_ready,
    output logic       o_en,
    output logic       o_valid,
    output t_pfb_bgra  o_pixel
);

    logic      w_lane_vld;
    t_pfb_bgra w_lane_px;
    logic      w_take;

    logic      r_out_vld;
    logic      n_out_vld;
    t_pfb_bgra r_out;
    t_pfb_bgra n_out;
    logic      r_skid_vld;
    logic      n_skid_vld;
    t_pfb_bgra r_skid;
    t_pfb_bgra n_skid;

    // Pack lane results into one pixel
    assign w_lane_vld = &i_lane_vld;
    assign w_lane_px  = '{blue: i_blue, green: i_green, red: i_red, alpha: ALPHA_OPAQUE};
    assign w_take     = !r_out_vld || i_out_ready;

    // Output register plus skid slot; lanes advance while the skid is empty
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (w_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out      = w_lane_px;
                n_out_vld  = w_lane_vld;
            end
        end else if (!r_skid_vld && w_lane_vld) begin
            n_skid     = w_lane_px;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_en    = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_pixel = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot holds a request while output is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid slot filled without an output stall");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lane_vld == 3'b000) || (i_lane_vld == 3'b111))
        else $error("lane valid bits disagree");

endmodule

/* rtl/core/pixel_format_to_bgra8.sv */
// Converts one source pixel word per clock into a BGRA8 pixel with alpha fixed
// at 255. Formats: BGRA8 pass-through, RGBA8 with red/blue swapped, RGB10A2
// rounded to bytes, and RGBA16F half floats scaled by the inverse white scale
// (Q1.15), clamped to 0..1 and sRGB-encoded through a linear segment or an
// interpolated power-curve table. Three channel lanes run side by side and a
// merge stage packs their bytes. Throughput is one pixel per clock while
// i_out_ready does not hold the output back; a request accepted at one clock
// edge loads the first lane stage and passes through the five lane stages
// (decode and multiply, exponent shift, table read, interpolation, rounding)
// and then the output register, which raises output valid. After reset the
// curve table is loaded into each lane's RAM, one entry per cycle, and
// o_pixel_ready stays low until the load is done. Configuration writes are
// taken at any time but should only be issued while no pixel is in flight.
module pixel_format_to_bgra8
    import pfb_pkg::*;
#(
    parameter int unsigned SRGB_TABLE_INDEX_BITS = SRGB_TABLE_INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_pixel_valid,
    output logic                   o_pixel_ready,
    input  logic [63:0]            i_pixel_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_blue_out,
    output logic [7:0]             o_green_out,
    output logic [7:0]             o_red_out,
    output logic [7:0]             o_alpha_out
);

    localparam int unsigned LANE_BLUE  = 0;
    localparam int unsigned LANE_GREEN = 1;
    localparam int unsigned LANE_RED   = 2;
    localparam int unsigned LANES      = 3;

    // Configuration registers
    t_src_fmt    r_source_format;
    logic [15:0] r_inv_white_scale;
    t_pfb_cfg    w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format   <= SOURCE_FORMAT_RST;
            r_inv_white_scale <= INV_WHITE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_FORMAT:   r_source_format   <= t_src_fmt'(i_cfg_data[1:0]);
                CFG_INV_WHITE_SCALE: r_inv_white_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg = '{source_format: r_source_format, inv_white_scale: r_inv_white_scale};

    // Table load after reset
    logic                         w_tbl_we;
    logic [SRGB_TABLE_INDEX_BITS:0] w_tbl_waddr;
    logic [TBL_DATA_W-1:0]        w_tbl_wdata;
    logic                         w_fill_done;

    pfb_table_fill #(
        .IDX_BITS (SRGB_TABLE_INDEX_BITS)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (w_tbl_we),
        .o_waddr (w_tbl_waddr),
        .o_wdata (w_tbl_wdata),
        .o_done  (w_fill_done)
    );

    // Request accept and pipeline advance
    logic w_en;
    logic w_accept;

    assign o_pixel_ready = w_fill_done && w_en;
    assign w_accept      = i_pixel_valid && o_pixel_ready;

    // Per lane channel fields
    logic        w_bgra_order;
    logic [15:0] w_half  [LANES];
    logic [9:0]  w_unorm [LANES];
    logic [7:0]  w_byte  [LANES];

    assign w_bgra_order = (r_source_format == FMT_BGRA8);

    assign w_half[LANE_BLUE]   = i_pixel_word[47:32];
    assign w_half[LANE_GREEN]  = i_pixel_word[31:16];
    assign w_half[LANE_RED]    = i_pixel_word[15:0];
    assign w_unorm[LANE_BLUE]  = i_pixel_word[29:20];
    assign w_unorm[LANE_GREEN] = i_pixel_word[19:10];
    assign w_unorm[LANE_RED]   = i_pixel_word[9:0];
    assign w_byte[LANE_BLUE]   = w_bgra_order ? i_pixel_word[7:0] : i_pixel_word[23:16];
    assign w_byte[LANE_GREEN]  = i_pixel_word[15:8];
    assign w_byte[LANE_RED]    = w_bgra_order ? i_pixel_word[23:16] : i_pixel_word[7:0];

    logic [LANES-1:0] w_lane_vld;
    logic [7:0]       w_lane_byte [LANES];

    for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        pfb_lane #(
            .IDX_BITS (SRGB_TABLE_INDEX_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_valid     (w_accept),
            .i_cfg       (w_cfg),
            .i_half      (w_half[gl]),
            .i_unorm     (w_unorm[gl]),
            .i_byte      (w_byte[gl]),
            .i_tbl_we    (w_tbl_we),
            .i_tbl_waddr (w_tbl_waddr),
            .i_tbl_wdata (w_tbl_wdata),
            .o_valid     (w_lane_vld[gl]),
            .o_byte      (w_lane_byte[gl])
        );
    end

    // Merge lanes into the output pixel
    t_pfb_bgra w_pixel;

    pfb_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lane_vld  (w_lane_vld),
        .i_blue      (w_lane_byte[LANE_BLUE]),
        .i_green     (w_lane_byte[LANE_GREEN]),
        .i_red       (w_lane_byte[LANE_RED]),
        .i_out_ready (i_out_ready),
        .o_en        (w_en),
        .o_valid     (o_out_valid),
        .o_pixel     (w_pixel)
    );

    assign o_blue_out  = w_pixel.blue;
    assign o_green_out = w_pixel.green;
    assign o_red_out   = w_pixel.red;
    assign o_alpha_out = w_pixel.alpha;

endmodule
